/* src/slt_pkg.sv */
`default_nettype none
package slt_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int DEF_CAPACITY = 16;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_SHOW   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast to the whole chain
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/slt_cell.sv */
`default_nettype none
module slt_cell (
  input  wire logic                              clk,
  input  wire slt_pkg::cell_ctrl_t               ctrl,
  input  wire logic                              occupied,
  input  wire logic                              tail,
  input  wire logic signed [slt_pkg::DATA_W-1:0] left_entry,
  input  wire logic signed [slt_pkg::DATA_W-1:0] right_entry,
  input  wire logic signed [slt_pkg::DATA_W-1:0] head_entry,
  input  wire logic                              gt_prev,
  input  wire logic                              ge_prev,
  output logic signed [slt_pkg::DATA_W-1:0]      entry,
  output logic                                   gt,
  output logic                                   ge,
  output logic                                   hit
);
  import slt_pkg::*;

  logic signed [DATA_W-1:0] entry_next;

  // Compare the held value against the broadcast operand
  assign gt  = occupied && (entry > ctrl.value);
  assign ge  = occupied && (entry >= ctrl.value);
  // First cell at or above the operand, and equal to it
  assign hit = ge && !ge_prev && (entry == ctrl.value);

  // Pick the next value: shift right on insert, left on remove, rotate on show
  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      CELL_INSERT: begin
        if (gt_prev) begin
          entry_next = left_entry;
        end else if (gt || !occupied) begin
          entry_next = ctrl.value;
        end
      end
      CELL_REMOVE: begin
        if (ge) begin
          entry_next = right_entry;
        end
      end
      CELL_ROTATE: begin
        entry_next = tail ? head_entry : right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

/* src/sorted_list_table_core.sv */
`default_nettype none
// Sorted table of up to CAPACITY signed 32-bit values, held in ascending order
// in a chain of cells. Input items carry a command in tdata[1:0] and a value in
// tdata[33:2]. Insert, remove and clear each update the cell chain
// and give one result item; an insert on a full table is rejected with status
// full, a remove of an absent value gives status not-found. Show streams the
// stored values from the head cell, one per cycle while the output is not
// stalled, and the chain rotates left by one cell per value sent, so a show
// of N values returns the table to its original order; on an empty table it
// gives one item with status empty. No input item is accepted during a show.
// Results wait in a single output register; entry_count is the count after the
// command, cut to five bits.
module sorted_list_table_core #(
  parameter int CAPACITY = slt_pkg::DEF_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] command, [33:2] value, [39:34] zero
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [33:2] element, [38:34] entry_count, [39] zero
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import slt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SHOW = 1'b1;

  logic                     state, state_next;
  logic [CW-1:0]            count, count_next, count_m1;
  logic [CW-1:0]            idx, idx_next;
  logic                     in_fire, out_free, out_load, full, found;
  logic [1:0]               cmd;
  cell_op_t                 cell_op;
  cell_ctrl_t               ctrl;
  logic [1:0]               status_d, status_q;
  logic signed [DATA_W-1:0] element_d, element_q;
  logic                     last_d, last_q;
  logic [COUNT_OUT_W-1:0]   count_q;

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      gt, ge, hit;

  assign cmd        = s_axis_tdata[1:0];
  assign ctrl       = '{op: cell_op, value: s_axis_tdata[33:2]};
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign full       = (count == CW'(CAPACITY));
  assign count_m1   = count - 1'b1;
  assign found      = |hit;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic signed [DATA_W-1:0] left_e, right_e;
    logic                     gt_p, ge_p;
    if (i == 0) begin : g_head
      assign left_e = ctrl.value;
      assign gt_p   = 1'b0;
      assign ge_p   = 1'b0;
    end else begin : g_body
      assign left_e = entry[i-1];
      assign gt_p   = gt[i-1];
      assign ge_p   = ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_e = entry[i];
    end else begin : g_mid
      assign right_e = entry[i+1];
    end
    slt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (IDX < count),
      .tail        (IDX == count_m1),
      .left_entry  (left_e),
      .right_entry (right_e),
      .head_entry  (entry[0]),
      .gt_prev     (gt_p),
      .ge_prev     (ge_p),
      .entry       (entry[i]),
      .gt          (gt[i]),
      .ge          (ge[i]),
      .hit         (hit[i])
    );
  end

  // Decode the command and step the show stream
  always_comb begin
    cell_op    = CELL_HOLD;
    state_next = state;
    count_next = count;
    idx_next   = idx;
    out_load   = 1'b0;
    status_d   = ST_OK;
    element_d  = '0;
    last_d     = 1'b1;
    if (state == S_SHOW) begin
      if (out_free) begin
        out_load  = 1'b1;
        cell_op   = CELL_ROTATE;
        element_d = entry[0];
        last_d    = (idx == count_m1);
        idx_next  = idx + 1'b1;
        if (idx == count_m1) begin
          state_next = S_IDLE;
        end
      end
    end else if (in_fire) begin
      out_load = 1'b1;
      case (cmd)
        CMD_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_op    = CELL_INSERT;
            count_next = count + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            cell_op    = CELL_REMOVE;
            count_next = count_m1;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
        CMD_CLEAR: begin
          count_next = '0;
        end
        CMD_SHOW: begin
          if (count == '0) begin
            status_d = ST_EMPTY;
          end else begin
            out_load   = 1'b0;
            state_next = S_SHOW;
            idx_next   = '0;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_q  <= status_d;
      element_q <= element_d;
      count_q   <= COUNT_OUT_W'(count_next);
      last_q    <= last_d;
    end
  end

  assign m_axis_tdata = {1'b0, count_q, element_q, status_q};
  assign m_axis_tlast = last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_no_accept_in_show: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> !s_axis_tready)
    else $error("input accepted during show");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status_q == ST_EMPTY) |-> (count_q == '0 && last_q))
    else $error("empty status with stored values");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status_q == ST_FULL) |-> (count_q == COUNT_OUT_W'(CAPACITY)))
    else $error("full status below capacity");

  a_show_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_SHOW && count != '0) |=> (state == S_SHOW && idx == '0))
    else $error("show did not start");

endmodule
`default_nettype wire
